FILE: src/rfc_pkg.sv
// rfc_pkg: shared constants, status codes, helper functions and types for the
// response frame checker. No dependencies; imported by rfc_classify and the top.
package rfc_pkg;

   localparam int MAX_FRAME_DEF = 256;
   localparam int MIN_FRAME     = 14;

   localparam int STATUS_W = 3;
   localparam int CODE_W   = 7;
   localparam int LEN_W    = 9;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SUM   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WARN  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ERR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SHORT = 3'd4;

   localparam logic [CODE_W-1:0] CODE_WARN_A = 7'd21;
   localparam logic [CODE_W-1:0] CODE_WARN_B = 7'd23;

   typedef struct packed {
      logic [7:0]  sum;
      logic [7:0]  hex_hi;
      logic [7:0]  hex_lo;
      logic [15:0] code_chars;
      logic        short_frame;
   } frame_tail_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

FILE: src/rfc_classify.sv
// rfc_classify: checksum compare, response code parse and status select for
// a frame that ends on the current word. Depends on rfc_pkg.
module rfc_classify
   import rfc_pkg::*;
(
   input  frame_tail_type        tail,
   output logic [STATUS_W-1:0]   status,
   output logic [CODE_W-1:0]     code
);

   logic [7:0]        expect_sum;
   logic              sum_ok;
   logic [7:0]        hi_char;
   logic [7:0]        lo_char;
   logic [CODE_W-1:0] hi_val;
   logic [CODE_W-1:0] lo_val;
   logic [CODE_W-1:0] parsed;

   assign expect_sum = 8'd0 - tail.sum;
   assign sum_ok     = (tail.hex_hi == hex_char(expect_sum[7:4])) &&
                       (tail.hex_lo == hex_char(expect_sum[3:0]));

   assign hi_char = tail.code_chars[15:8];
   assign lo_char = tail.code_chars[7:0];
   assign hi_val  = {3'b000, hi_char[3:0]};
   assign lo_val  = {3'b000, lo_char[3:0]};

   always_comb begin
      if (!is_digit(hi_char)) begin
         parsed = '0;
      end else if (!is_digit(lo_char)) begin
         parsed = hi_val;
      end else begin
         parsed = (hi_val << 3) + (hi_val << 1) + lo_val;
      end
   end

   always_comb begin
      code = '0;
      if (tail.short_frame) begin
         status = ST_SHORT;
      end else if (!sum_ok) begin
         status = ST_SUM;
      end else begin
         code = parsed;
         if (parsed == '0) begin
            status = ST_OK;
         end else if (parsed == CODE_WARN_A || parsed == CODE_WARN_B) begin
            status = ST_WARN;
         end else begin
            status = ST_ERR;
         end
      end
   end

endmodule

FILE: src/response_frame_checker_unit.sv
// response_frame_checker_unit: top level; tracks the frame tail, sum and count
// per word and registers one status word per CR LF. Depends on rfc_pkg, rfc_classify.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_ready  req_rx_byte[7:0]
//   rsp_     out  rsp_valid/rsp_ready  rsp_frame_status[2:0], rsp_response_code[6:0],
//                                      rsp_frame_length[8:0]
//
// One word per cycle while req_ready; status shows in the cycle after the final LF.
// Frame state updates on the accepting edge; the result register decouples the sides.
// req_ready drops only while a status word waits and rsp_ready is low.
// Synchronous reset clears the frame state and the result valid; no clearing pass.
module response_frame_checker_unit
   import rfc_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_frame_status,
   output logic [CODE_W-1:0]   rsp_response_code,
   output logic [LEN_W-1:0]    rsp_frame_length
);

   localparam int CW = $clog2(MAX_FRAME + 1);

   logic [31:0]         win_ff, win_in;
   logic [7:0]          sum_ff, sum_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [15:0]         code_ff, code_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CODE_W-1:0]   code_out_ff;
   logic [LEN_W-1:0]    len_ff;

   logic                accept;
   logic                ends;
   logic [CW+LEN_W-1:0] len_wide;
   frame_tail_type      tail;
   logic [STATUS_W-1:0] status_in;
   logic [CODE_W-1:0]   code_out_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign ends = (req_rx_byte == CH_LF) && (count_ff != '0) && (win_ff[7:0] == CH_CR);

   assign sum_in   = (count_ff >= CW'(4)) ? sum_ff + win_ff[31:24] : sum_ff;
   assign win_in   = {win_ff[23:0], req_rx_byte};
   assign count_in = (count_ff == CW'(MAX_FRAME)) ? count_ff : count_ff + 1'b1;

   always_comb begin
      code_in = code_ff;
      if (count_ff == CW'(7)) begin
         code_in[15:8] = req_rx_byte;
      end else if (count_ff == CW'(8)) begin
         code_in[7:0] = req_rx_byte;
      end
   end

   assign len_wide = {{LEN_W{1'b0}}, count_in};

   assign tail.sum         = sum_in;
   assign tail.hex_hi      = win_in[31:24];
   assign tail.hex_lo      = win_in[23:16];
   assign tail.code_chars  = code_in;
   assign tail.short_frame = (count_in < CW'(MIN_FRAME));

   rfc_classify u_classify (
      .tail   (tail),
      .status (status_in),
      .code   (code_out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         code_ff  <= '0;
      end else if (accept) begin
         if (ends) begin
            win_ff   <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
            code_ff  <= '0;
         end else begin
            win_ff   <= win_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
            code_ff  <= code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && ends) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && ends) begin
         status_ff   <= status_in;
         code_out_ff <= code_out_in;
         len_ff      <= len_wide[LEN_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_response_code = code_out_ff;
   assign rsp_frame_length  = len_ff;

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      (accept && ends) |=> rsp_valid)
      else $error("frame end did not produce a status word");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && ends) |=> (count_ff == '0 && sum_ff == '0 && win_ff == '0))
      else $error("frame state not cleared after frame end");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status == ST_SHORT) |->
         (rsp_frame_length < LEN_W'(MIN_FRAME) && rsp_response_code == '0))
      else $error("too-short status with long frame or nonzero code");

   a_warn_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status == ST_WARN) |->
         (rsp_response_code == CODE_WARN_A || rsp_response_code == CODE_WARN_B))
      else $error("warning status with non-warning code");

endmodule

FILE: sim/response_frame_checker_unit_tb.sv
// response_frame_checker_unit_tb: streams reply bytes into the frame checker and
// compares every status word against a frame-by-frame model of checksum, code and length.
// Depends on rfc_pkg and response_frame_checker_unit.
`timescale 1ns / 1ps

module response_frame_checker_unit_tb
   import rfc_pkg::*;
;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CODE_W-1:0]   code;
      logic [LEN_W-1:0]    frame_len;
   } status_word_type;

   function automatic logic [7:0] to_hex(input logic [3:0] nib);
      logic [127:0] digits;
      digits = "0123456789ABCDEF";
      return digits[8*(15-nib) +: 8];
   endfunction

   class status_scoreboard;
      logic [31:0]     tail_window;
      logic [7:0]      leaving_sum;
      logic [8:0]      word_count;
      logic [15:0]     code_chars;
      status_word_type expected_q[$];
      int              mismatch_count;

      function new();
         clear_frame();
         mismatch_count = 0;
      endfunction

      function void clear_frame();
         tail_window = '0;
         leaving_sum = '0;
         word_count  = '0;
         code_chars  = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic numeral(input logic [7:0] c);
         return (c >= 8'h30) && (c <= 8'h39);
      endfunction

      function logic [CODE_W-1:0] response_value(input logic [15:0] chars);
         int tens;
         int ones;
         tens = int'(chars[15:8]) - 8'h30;
         ones = int'(chars[7:0]) - 8'h30;
         if (!numeral(chars[15:8]))
            return '0;
         if (!numeral(chars[7:0]))
            return tens[CODE_W-1:0];
         return CODE_W'(tens * 10 + ones);
      endfunction

      function void note_rx_word(input logic [7:0] value);
         logic            frame_end;
         logic [8:0]      pos;
         logic [7:0]      want_sum;
         status_word_type want;
         frame_end = (value == CH_LF) && (word_count >= 1) && (tail_window[7:0] == CH_CR);
         pos = word_count;
         if (word_count >= 4)
            leaving_sum = leaving_sum + tail_window[31:24];
         tail_window = {tail_window[23:0], value};
         if (pos == 7)
            code_chars[15:8] = value;
         else if (pos == 8)
            code_chars[7:0] = value;
         if (word_count < MAX_FRAME_DEF)
            word_count = word_count + 1'b1;
         if (!frame_end)
            return;
         want.frame_len = word_count;
         want.code = '0;
         if (word_count < MIN_FRAME) begin
            want.status = ST_SHORT;
         end else begin
            want_sum = 8'h00 - leaving_sum;
            if (tail_window[31:24] != to_hex(want_sum[7:4]) ||
                tail_window[23:16] != to_hex(want_sum[3:0])) begin
               want.status = ST_SUM;
            end else begin
               want.code = response_value(code_chars);
               if (want.code == '0)
                  want.status = ST_OK;
               else if (want.code == CODE_WARN_A || want.code == CODE_WARN_B)
                  want.status = ST_WARN;
               else
                  want.status = ST_ERR;
            end
         end
         expected_q.push_back(want);
         clear_frame();
      endfunction

      function void report(input string msg);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("MISMATCH %s", msg);
      endfunction

      function void check_status_word(input status_word_type got);
         status_word_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word: status %0d code %0d length %0d",
                             got.status, got.code, got.frame_len));
            return;
         end
         want = expected_q.pop_front();
         if (got.status != want.status || got.code != want.code ||
             got.frame_len != want.frame_len)
            report($sformatf("expected status %0d code %0d length %0d, got %0d %0d %0d",
                             want.status, want.code, want.frame_len,
                             got.status, got.code, got.frame_len));
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_frame_status;
   logic [CODE_W-1:0]   rsp_response_code;
   logic [LEN_W-1:0]    rsp_frame_length;

   status_scoreboard sb;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int sent_words = 0;

   response_frame_checker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_response_code (rsp_response_code),
      .rsp_frame_length  (rsp_frame_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("response_frame_checker_unit_tb NOT OK");
      $finish;
   end

   initial begin : receiver
      status_word_type seen;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen.status = rsp_frame_status;
            seen.code = rsp_response_code;
            seen.frame_len = rsp_frame_length;
            sb.check_status_word(seen);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_word(input logic [7:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_rx_word(value);
      sent_words++;
   endtask

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      if ($urandom_range(1))
         c = 8'($urandom_range(8'h2F));
      else
         c = 8'($urandom_range(8'hFF, 8'h3A));
      return c;
   endfunction

   task automatic send_reply(input int body_len, input int code_kind, input bit bad_sum);
      logic [7:0] body[$];
      logic [7:0] b;
      logic [7:0] sum;
      logic [7:0] chk;
      logic [7:0] hi_c;
      logic [7:0] lo_c;
      int i;
      sum = 8'h00;
      for (i = 0; i < body_len; i++) begin
         b = 8'($urandom_range(255));
         body.push_back(b);
      end
      if (body_len > 8) begin
         case (code_kind)
            0: begin
               body[7] = "0";
               body[8] = "0";
            end
            1: begin
               body[7] = "2";
               body[8] = "1";
            end
            2: begin
               body[7] = "2";
               body[8] = "3";
            end
            3: begin
               body[7] = 8'h30 + 8'($urandom_range(9));
               body[8] = 8'h30 + 8'($urandom_range(9));
            end
            4: begin
               body[7] = 8'h30 + 8'($urandom_range(9));
               body[8] = non_digit();
            end
            5: body[7] = non_digit();
            default: ;
         endcase
      end
      // keep the frame from ending early
      for (i = 1; i < body_len; i++)
         if (body[i] == CH_LF && body[i-1] == CH_CR)
            body[i] = 8'h0B;
      for (i = 0; i < body_len; i++) begin
         sum = sum + body[i];
         send_word(body[i]);
      end
      chk = 8'h00 - sum;
      hi_c = to_hex(chk[7:4]);
      lo_c = to_hex(chk[3:0]);
      if (bad_sum) begin
         if ($urandom_range(1))
            hi_c = hi_c ^ (8'h01 << $urandom_range(7));
         else
            lo_c = lo_c ^ (8'h01 << $urandom_range(7));
      end
      send_word(hi_c);
      send_word(lo_c);
      send_word(CH_CR);
      send_word(CH_LF);
   endtask

   task automatic send_noise();
      logic [7:0] b;
      int n;
      int k;
      n = $urandom_range(12, 1);
      repeat (n) begin
         k = $urandom_range(9);
         if (k == 0)
            b = CH_CR;
         else if (k == 1)
            b = CH_LF;
         else
            b = 8'($urandom_range(255));
         send_word(b);
      end
   endtask

   task automatic send_random_reply();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         send_reply($urandom_range(24, 10), $urandom_range(6), 1'b0);
      else if (pick < 70)
         send_reply($urandom_range(24, 10), $urandom_range(6), 1'b1);
      else if (pick < 82)
         send_reply($urandom_range(9), $urandom_range(6), 1'b0);
      else
         send_noise();
   endtask

   initial begin : stimulus
      int phase;
      int phase_base;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_word(CH_CR);
      send_word(CH_LF);
      send_word(8'h00);
      send_word(8'hFF);
      send_word(CH_LF);
      send_word(CH_CR);
      send_word(CH_LF);
      send_reply(10, 1, 1'b0);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            default: begin
               sender_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         phase_base = sent_words;
         if (phase == 0) begin
            // hold off the receiver so the minimum-length replies stall on req_ready
            hold_request = 60;
            repeat (4) send_reply(10, $urandom_range(6), 1'b0);
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0)
               @(posedge clock);
            send_reply(300, $urandom_range(6), 1'b0);
         end
         while (sent_words - phase_base < 150)
            send_random_reply();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("response_frame_checker_unit_tb OK");
      else
         $display("response_frame_checker_unit_tb NOT OK");
      $finish;
   end
endmodule

FILE: files.f
src/rfc_pkg.sv
src/rfc_classify.sv
src/response_frame_checker_unit.sv
sim/response_frame_checker_unit_tb.sv
